FILE: rtl/tlptm_pkg.sv
// shared types and constants for the two-level page table mapper
// no dependencies; imported by every other file of the block except tlptm_ram
`default_nettype none

package tlptm_pkg;

  localparam int unsigned IDX_W          = 10;
  localparam int unsigned TABLE_ENTRIES  = 1024;
  localparam int unsigned DIR_ENTRIES    = 1024;
  localparam int unsigned PAGE_W         = 20;
  localparam int unsigned ENTRY_W        = 23;
  localparam int unsigned DIR_SHIFT      = 22;
  localparam int unsigned PAGE_SHIFT     = 12;
  localparam int unsigned POOL_TABLES_DEF = 8;

  localparam logic [PAGE_W-1:0] POOL_BASE_RESET = 20'd256;

  localparam logic KIND_MAP   = 1'b0;
  localparam logic KIND_UNMAP = 1'b1;

  typedef enum logic [1:0] {
    ST_APPLIED  = 2'd0,
    ST_SKIPPED  = 2'd1,
    ST_NO_TABLE = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_CLR_DIR,
    S_IDLE,
    S_LOOKUP,
    S_POOL_CLR,
    S_REPLY
  } state_e;

  typedef struct packed {
    logic        kind;
    logic [31:0] virt_addr;
    logic [31:0] phys_addr;
    logic [2:0]  attrs;
  } item_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] dir_entry;
    logic [31:0] table_entry;
    logic        allocated;
    logic        tlb_flush;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic decide;
    logic clr_dir;
    logic clr_pool;
    logic commit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_alloc;
    logic sweep_last;
  } stat_t;

endpackage

`default_nettype wire

FILE: rtl/tlptm_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module tlptm_ram #(
  parameter int unsigned WIDTH = 23,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/tlptm_ctrl.sv
// sequencing state machine of the mapper
// depends on tlptm_pkg
`default_nettype none

module tlptm_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start,
  output logic                 busy,
  output logic                 done_o,
  output tlptm_pkg::cmd_t      cmd_o,
  input  wire tlptm_pkg::stat_t stat_i
);

  import tlptm_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR_DIR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLR_DIR:  if (stat_i.sweep_last) state_d = S_IDLE;
      S_IDLE:     if (start) state_d = S_LOOKUP;
      S_LOOKUP:   state_d = stat_i.need_alloc ? S_POOL_CLR : S_REPLY;
      S_POOL_CLR: if (stat_i.sweep_last) state_d = S_REPLY;
      S_REPLY:    state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  always_comb begin
    busy           = (state_q != S_IDLE);
    done_o         = (state_q == S_REPLY);
    cmd_o.accept   = (state_q == S_IDLE) && start;
    cmd_o.decide   = (state_q == S_LOOKUP);
    cmd_o.clr_dir  = (state_q == S_CLR_DIR);
    cmd_o.clr_pool = (state_q == S_POOL_CLR);
    cmd_o.commit   = (state_q == S_REPLY);
  end

endmodule

`default_nettype wire

FILE: rtl/tlptm_datapath.sv
// datapath: config register, item latch, directory and pool rams, decision logic
// depends on tlptm_pkg and tlptm_ram
`default_nettype none

module tlptm_datapath #(
  parameter int unsigned POOL_TABLES = tlptm_pkg::POOL_TABLES_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [tlptm_pkg::PAGE_W-1:0] cfg_wdata_i,
  input  wire tlptm_pkg::item_t          item_i,
  input  wire tlptm_pkg::cmd_t           cmd_i,
  output tlptm_pkg::stat_t               stat_o,
  output tlptm_pkg::result_t             result_o
);

  import tlptm_pkg::*;

  localparam int unsigned SLOT_W = (POOL_TABLES > 1) ? $clog2(POOL_TABLES) : 1;
  localparam int unsigned CNT_W  = $clog2(POOL_TABLES + 1);
  localparam int unsigned PDEPTH = POOL_TABLES * TABLE_ENTRIES;
  localparam int unsigned PA_W   = $clog2(PDEPTH);

  logic [PAGE_W-1:0]  cfg_base_q;
  item_t              item_q;
  logic [CNT_W-1:0]   next_slot_q;
  logic [IDX_W-1:0]   sweep_q;
  result_t            res_q, res_d;

  // commit plan
  logic               wr_dir_q, wr_dir_d;
  logic               wr_pool_q, wr_pool_d;
  logic               alloc_q, alloc_d;
  logic [SLOT_W-1:0]  slot_q, slot_d;
  logic [ENTRY_W-1:0] dir_word_q, dir_word_d;
  logic [ENTRY_W-1:0] tab_word_q, tab_word_d;

  logic [ENTRY_W-1:0] dir_rd;
  logic [PAGE_W-1:0]  rel;
  logic               in_pool;
  logic               exhausted;

  logic [IDX_W-1:0]   dir_idx;
  logic [IDX_W-1:0]   tab_idx;

  assign dir_idx = item_q.virt_addr[DIR_SHIFT +: IDX_W];
  assign tab_idx = item_q.virt_addr[PAGE_SHIFT +: IDX_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_base_q  <= POOL_BASE_RESET;
      next_slot_q <= '0;
      sweep_q     <= '0;
    end else begin
      if (cfg_we_i) cfg_base_q <= cfg_wdata_i;
      if (cmd_i.commit && alloc_q) next_slot_q <= next_slot_q + CNT_W'(1);
      if (cmd_i.clr_dir || cmd_i.clr_pool) sweep_q <= sweep_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) item_q <= item_i;
    if (cmd_i.decide) begin
      res_q      <= res_d;
      wr_dir_q   <= wr_dir_d;
      wr_pool_q  <= wr_pool_d;
      alloc_q    <= alloc_d;
      slot_q     <= slot_d;
      dir_word_q <= dir_word_d;
      tab_word_q <= tab_word_d;
    end
  end

  // slot of the table that a directory entry points at
  assign rel       = dir_rd[ENTRY_W-1:3] - cfg_base_q;
  assign in_pool   = (rel < PAGE_W'(POOL_TABLES));
  assign exhausted = (next_slot_q == CNT_W'(POOL_TABLES));

  always_comb begin
    wr_dir_d   = 1'b0;
    wr_pool_d  = 1'b0;
    alloc_d    = 1'b0;
    slot_d     = rel[SLOT_W-1:0];
    dir_word_d = dir_rd;
    tab_word_d = '0;
    res_d.status = ST_APPLIED;

    priority if (item_q.kind == KIND_UNMAP) begin
      priority if (!dir_rd[0]) begin
        res_d.status = ST_SKIPPED;
      end else if (!in_pool) begin
        res_d.status = ST_NO_TABLE;
      end else begin
        wr_pool_d = 1'b1;
      end
    end else if (!dir_rd[0]) begin
      if (exhausted) begin
        res_d.status = ST_NO_TABLE;
      end else begin
        // fresh table: present, rw and user all come from attrs
        alloc_d    = 1'b1;
        slot_d     = next_slot_q[SLOT_W-1:0];
        dir_word_d = {cfg_base_q + PAGE_W'(next_slot_q), item_q.attrs};
        wr_dir_d   = 1'b1;
        wr_pool_d  = 1'b1;
        tab_word_d = {item_q.phys_addr[31:PAGE_SHIFT], item_q.attrs};
      end
    end else if (!in_pool) begin
      res_d.status = ST_NO_TABLE;
    end else begin
      // existing table: only rw is overwritten
      dir_word_d = {dir_rd[ENTRY_W-1:2], item_q.attrs[1], dir_rd[0]};
      wr_dir_d   = 1'b1;
      wr_pool_d  = 1'b1;
      tab_word_d = {item_q.phys_addr[31:PAGE_SHIFT], item_q.attrs};
    end

    res_d.dir_entry   = {dir_word_d[ENTRY_W-1:3], 9'd0, dir_word_d[2:0]};
    res_d.table_entry = {tab_word_d[ENTRY_W-1:3], 9'd0, tab_word_d[2:0]};
    res_d.allocated   = alloc_d;
    res_d.tlb_flush   = wr_pool_d;
  end

  tlptm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DIR_ENTRIES)
  ) u_dir_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.clr_dir || (cmd_i.commit && wr_dir_q)),
    .waddr_i (cmd_i.clr_dir ? sweep_q : dir_idx),
    .wdata_i (cmd_i.clr_dir ? {ENTRY_W{1'b0}} : dir_word_q),
    .re_i    (cmd_i.accept),
    .raddr_i (item_i.virt_addr[DIR_SHIFT +: IDX_W]),
    .rdata_o (dir_rd)
  );

  tlptm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (PDEPTH)
  ) u_pool_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.clr_pool || (cmd_i.commit && wr_pool_q)),
    .waddr_i (PA_W'({slot_q, (cmd_i.clr_pool ? sweep_q : tab_idx)})),
    .wdata_i (cmd_i.clr_pool ? {ENTRY_W{1'b0}} : tab_word_q),
    .re_i    (1'b0),
    .raddr_i ({PA_W{1'b0}}),
    .rdata_o ()
  );

  assign stat_o.need_alloc = alloc_d;
  assign stat_o.sweep_last = &sweep_q;
  assign result_o          = res_q;

endmodule

`default_nettype wire

FILE: rtl/two_level_page_table_mapper_core.sv
// top level of the two-level page table mapper: controller plus datapath
// depends on tlptm_pkg, tlptm_ctrl, tlptm_datapath, tlptm_ram
//
//  channel   | ports                         | handshake
//  ----------+-------------------------------+------------------------------------
//  item in   | item_i (item_t)               | taken at edge with start && !busy
//  result    | result_o (result_t)           | done_o high one cycle, always taken
//  config    | cfg_wdata_i (20 bit)          | written at edge with cfg_we_i high
//
// an item passes through accept, directory lookup and decision, commit and reply
// a map that links a new page table first clears that table through the pool
// ram write port, one entry a cycle, before its commit and reply
// after reset busy stays high during a pass that clears the directory
// the receiver cannot stall; done_o is a single-cycle strobe
`default_nettype none

module two_level_page_table_mapper_core #(
  parameter int unsigned POOL_TABLES = tlptm_pkg::POOL_TABLES_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // item channel
  input  wire logic                         start,
  output logic                              busy,
  input  wire tlptm_pkg::item_t             item_i,
  // result channel
  output logic                              done_o,
  output tlptm_pkg::result_t                result_o,
  // configuration: pool base page
  input  wire logic                         cfg_we_i,
  input  wire logic [tlptm_pkg::PAGE_W-1:0] cfg_wdata_i
);

  import tlptm_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // sequencer: reset clear, lookup, optional pool table clear, reply
  tlptm_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .cmd_o  (cmd),
    .stat_i (stat)
  );

  // directory and pool storage with the map/unmap decision
  tlptm_datapath #(
    .POOL_TABLES (POOL_TABLES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_i      (item_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .result_o    (result_o)
  );

endmodule

`default_nettype wire

FILE: rtl/tlptm_checker.sv
// port-level checks for the mapper top level, bound in below
// depends on tlptm_pkg and two_level_page_table_mapper_core
`default_nettype none

module tlptm_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               start,
  input wire logic               busy,
  input wire logic               done_o,
  input wire tlptm_pkg::result_t result_o
);

  import tlptm_pkg::*;

  // a reply only comes while an item is in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> busy)
    else $error("result strobe while idle");

  // an accepted item keeps the block busy in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) (start && !busy) |=> busy)
    else $error("busy did not rise after accept");

  // one result per item
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  // a skipped or refused item changes nothing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.status != ST_APPLIED) |->
      (!result_o.tlb_flush && !result_o.allocated && result_o.table_entry == 32'd0))
    else $error("refused item reports a change");

  // a new table is only taken by an applied map
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.allocated) |->
      (result_o.tlb_flush && result_o.status == ST_APPLIED))
    else $error("allocation without applied change");

endmodule

bind two_level_page_table_mapper_core tlptm_checker u_tlptm_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .done_o   (done_o),
  .result_o (result_o)
);

`default_nettype wire

FILE: dv/two_level_page_table_mapper_core_test.sv
// self-checking testbench for two_level_page_table_mapper_core
// drives map and unmap items, predicts every result with an in-bench scoreboard
// depends on tlptm_pkg and the rtl of the block only
`timescale 1ns / 1ps

module two_level_page_table_mapper_core_test;
  import tlptm_pkg::*;

  localparam int unsigned POOL      = POOL_TABLES_DEF;
  localparam int unsigned MAX_CYCLE = 400000;

  // mirror of the block: directory contents, pool bump counter, pool base
  // the table entries themselves never show up in a result, so they are not kept
  class map_scoreboard;
    logic [31:0]       dir_mem [DIR_ENTRIES];
    int unsigned       next_slot;
    logic [PAGE_W-1:0] pool_base;
    result_t           expected_q [$];
    logic [IDX_W-1:0]  linked_dirs [$];
    int unsigned       errors;
    int unsigned       shown;
    int unsigned       n_applied;
    int unsigned       n_skipped;
    int unsigned       n_no_table;
    int unsigned       n_linked;

    function new();
      foreach (dir_mem[i]) dir_mem[i] = '0;
      next_slot  = 0;
      pool_base  = POOL_BASE_RESET;
      errors     = 0;
      shown      = 0;
      n_applied  = 0;
      n_skipped  = 0;
      n_no_table = 0;
      n_linked   = 0;
    endfunction

    function void set_pool_base(logic [PAGE_W-1:0] v);
      pool_base = v;
    endfunction

    // pool slot that a directory entry points at, POOL when outside the pool
    function int unsigned pool_slot(logic [31:0] d);
      logic [PAGE_W-1:0] rel;
      rel = d[31:PAGE_SHIFT] - pool_base;
      return (rel < POOL) ? int'(rel) : POOL;
    endfunction

    function void note_item(item_t it);
      logic [IDX_W-1:0]  di;
      logic [31:0]       d;
      logic [PAGE_W-1:0] tbase;
      int unsigned       slot;
      result_t           r;
      di            = it.virt_addr[31:DIR_SHIFT];
      d             = dir_mem[di];
      r.status      = ST_APPLIED;
      r.dir_entry   = d;
      r.table_entry = '0;
      r.allocated   = 1'b0;
      r.tlb_flush   = 1'b0;
      if (it.kind == KIND_UNMAP) begin
        if (!d[0]) begin
          r.status = ST_SKIPPED;
        end else if (pool_slot(d) >= POOL) begin
          r.status = ST_NO_TABLE;
        end else begin
          r.tlb_flush = 1'b1;
        end
      end else begin
        slot = POOL;
        if (!d[0]) begin
          // absent entry: link the next pool table if one is left
          if (next_slot < POOL) begin
            slot        = next_slot;
            next_slot   = next_slot + 1;
            tbase       = pool_base + PAGE_W'(slot);
            d           = {tbase, 9'd0, it.attrs[2], 1'b0, it.attrs[0]};
            r.allocated = 1'b1;
            n_linked++;
            linked_dirs.push_back(di);
          end
        end else begin
          slot = pool_slot(d);
        end
        if (slot >= POOL) begin
          r.status = ST_NO_TABLE;
        end else begin
          // rw of the directory entry always follows the latest map
          d[1]          = it.attrs[1];
          dir_mem[di]   = d;
          r.dir_entry   = d;
          r.table_entry = {it.phys_addr[31:PAGE_SHIFT], 9'd0, it.attrs};
          r.tlb_flush   = 1'b1;
        end
      end
      case (r.status)
        ST_APPLIED: n_applied++;
        ST_SKIPPED: n_skipped++;
        default:    n_no_table++;
      endcase
      expected_q.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        if (shown < 100) begin
          $display("%0t: result with none pending: expected nothing, actual %h", $time, got);
        end
        shown++;
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status || got.dir_entry !== want.dir_entry ||
          got.table_entry !== want.table_entry || got.allocated !== want.allocated ||
          got.tlb_flush !== want.tlb_flush) begin
        errors++;
        if (shown < 100) begin
          $display("%0t: mismatch expected st=%0d dir=%h tab=%h alloc=%b flush=%b",
                   $time, want.status, want.dir_entry, want.table_entry,
                   want.allocated, want.tlb_flush);
          $display("%0t:          actual   st=%0d dir=%h tab=%h alloc=%b flush=%b",
                   $time, got.status, got.dir_entry, got.table_entry,
                   got.allocated, got.tlb_flush);
        end else if (shown == 100) begin
          $display("%0t: further mismatches not shown", $time);
        end
        shown++;
      end
    endfunction
  endclass

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              start       = 1'b0;
  logic              busy;
  item_t             item_i      = '0;
  logic              done_o;
  result_t           result_o;
  logic              cfg_we_i    = 1'b0;
  logic [PAGE_W-1:0] cfg_wdata_i = '0;

  map_scoreboard     sb;
  int unsigned       cycle_cnt   = 0;
  int unsigned       n_items     = 0;
  int unsigned       n_settings  = 0;
  bit                gap_mode    = 1'b1;

  two_level_page_table_mapper_core #(
    .POOL_TABLES(POOL)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .item_i     (item_i),
    .done_o     (done_o),
    .result_o   (result_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #6 clk_i = ~clk_i;

  // watchdog: the slowest legal run stays far below this
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > MAX_CYCLE) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // observe all three channels at the clock edge, pre-edge values only
  always @(posedge clk_i) begin
    if (rst_ni) begin
      // an x on the strobe is checked too, so it cannot slip by
      if (done_o !== 1'b0) begin
        sb.check_result(result_o);
      end
      if (start && busy === 1'b0) begin
        sb.note_item(item_i);
      end
      if (cfg_we_i) begin
        sb.set_pool_base(cfg_wdata_i);
      end
    end
  end

  function automatic item_t mk_item(logic kind, logic [31:0] va, logic [31:0] pa,
                                    logic [2:0] attrs);
    item_t it;
    it.kind      = kind;
    it.virt_addr = va;
    it.phys_addr = pa;
    it.attrs     = attrs;
    return it;
  endfunction

  // mostly hit directory entries that already own a table, some nearby
  // entries that are likely absent, and some fully random addresses
  function automatic item_t rand_item();
    item_t       it;
    int unsigned r;
    r            = $urandom_range(0, 99);
    it.kind      = ($urandom_range(0, 2) == 0) ? KIND_UNMAP : KIND_MAP;
    it.virt_addr = $urandom;
    it.phys_addr = $urandom;
    it.attrs     = 3'($urandom_range(0, 7));
    // keep the present bit set most of the time
    if ($urandom_range(0, 3) != 0) begin
      it.attrs[0] = 1'b1;
    end
    if (r < 75 && sb.linked_dirs.size() > 0) begin
      it.virt_addr[31:DIR_SHIFT] = sb.linked_dirs[$urandom_range(0, sb.linked_dirs.size() - 1)];
    end else if (r < 90) begin
      it.virt_addr[31:DIR_SHIFT] = IDX_W'($urandom_range(0, 15));
    end
    return it;
  endfunction

  // hold start until the item is taken; start stays high into the next item
  // unless an idle burst follows
  task automatic send_item(input item_t it, input bit allow_gap);
    start  <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
    n_items++;
    if (allow_gap && gap_mode && $urandom_range(0, 2) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  endtask

  // stop sending and wait until every pending result has come back
  task automatic settle();
    start <= 1'b0;
    do @(posedge clk_i); while (sb.expected_q.size() != 0 || busy !== 1'b0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_pool_base(input logic [PAGE_W-1:0] v);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    n_settings++;
  endtask

  task automatic random_phase(input int unsigned count, input int unsigned calm_tail);
    for (int unsigned k = 0; k < count; k++) begin
      // switch between bursty and back-to-back stretches
      if ($urandom_range(0, 29) == 0) begin
        gap_mode = ~gap_mode;
      end
      send_item(rand_item(), k + calm_tail < count);
    end
  endtask

  initial begin
    sb = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    // wait out the directory clearing pass before the first item
    settle();

    // directed part, reset pool base: absent unmap, first link, rw clear,
    // unmap with ignored fields set
    send_item(mk_item(KIND_UNMAP, 32'h0000_0000, 32'hFFFF_FFFF, 3'd7), 1'b1);
    send_item(mk_item(KIND_MAP,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd7), 1'b1);
    send_item(mk_item(KIND_MAP,   32'hFFC0_0000, 32'h0000_0000, 3'd0), 1'b1);
    send_item(mk_item(KIND_UNMAP, 32'hFFFF_F123, 32'hA5A5_A5A5, 3'd7), 1'b1);

    // pool base near the top so that the pool page numbers wrap to zero
    write_pool_base(20'hFFFFE);
    // map without present bit: table taken, entry stays absent
    send_item(mk_item(KIND_MAP,   32'h0000_0000, 32'h1234_5678, 3'd6), 1'b1);
    // unmap of that absent entry
    send_item(mk_item(KIND_UNMAP, 32'h0000_0ABC, 32'h0000_0000, 3'd0), 1'b1);
    // same region again takes a further table, base wraps
    send_item(mk_item(KIND_MAP,   32'h0000_0000, 32'hFFFF_F000, 3'd1), 1'b1);
    send_item(mk_item(KIND_MAP,   32'h003F_F000, 32'h0000_0FFF, 3'd3), 1'b1);
    send_item(mk_item(KIND_UNMAP, 32'h003F_F000, 32'h0000_0000, 3'd0), 1'b1);
    send_item(mk_item(KIND_MAP,   32'h0040_0000, 32'h8000_0000, 3'd5), 1'b1);
    send_item(mk_item(KIND_MAP,   32'h8000_0000, 32'h7FFF_F000, 3'd7), 1'b1);
    send_item(mk_item(KIND_MAP,   32'h7FFF_F000, 32'h5555_5555, 3'd2), 1'b1);
    send_item(mk_item(KIND_MAP,   32'h5555_5555, 32'hAAAA_AAAA, 3'd7), 1'b1);
    send_item(mk_item(KIND_MAP,   32'hAAAA_AAAA, 32'h5555_5555, 3'd4), 1'b1);
    // pool now used up: a map that needs a table gets none
    send_item(mk_item(KIND_MAP,   32'h7FC0_0000, 32'h0000_1000, 3'd7), 1'b1);
    send_item(mk_item(KIND_UNMAP, 32'h7FC0_0000, 32'h0000_0000, 3'd0), 1'b1);
    // first table was linked under the old base, now outside the pool
    send_item(mk_item(KIND_MAP,   32'hFFC0_0000, 32'h0000_2000, 3'd7), 1'b1);

    // random part, a few pool base settings including both extremes;
    // each change of base is made with nothing in flight
    settle();
    random_phase(210, 0);
    write_pool_base(20'h00000);
    random_phase(210, 0);
    write_pool_base(20'hFFFFF);
    random_phase(210, 0);
    write_pool_base(POOL_BASE_RESET);
    // last stretch ends with a run of items sent back to back
    random_phase(210, 120);

    settle();
    repeat (16) @(posedge clk_i);

    $display("covered %0d items under %0d pool base writes, %0d tables linked",
             n_items, n_settings, sb.n_linked);
    $display("outcomes: %0d applied, %0d unmaps skipped, %0d refused for lack of a table",
             sb.n_applied, sb.n_skipped, sb.n_no_table);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
